[hw/rtl/hmt_pkg.sv]
// Shared types, constants and codes of the heartbeat membership table.
package hmt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 4;

	localparam logic [1:0] MODE_MERGE = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_DUMP  = 2'd2;

	localparam logic [1:0] REG_OWN_ID     = 2'd0;
	localparam logic [1:0] REG_OWN_PORT   = 2'd1;
	localparam logic [1:0] REG_FAIL_TO    = 2'd2;
	localparam logic [1:0] REG_REMOVE_TO  = 2'd3;

	localparam logic [2:0] CELL_HOLD      = 3'd0;
	localparam logic [2:0] CELL_MERGE     = 3'd1;
	localparam logic [2:0] CELL_HEAD_TICK = 3'd2;
	localparam logic [2:0] CELL_MARK_DEAD = 3'd3;
	localparam logic [2:0] CELL_MARK_LIVE = 3'd4;
	localparam logic [2:0] CELL_COMPACT   = 3'd5;
	localparam logic [2:0] CELL_ROTATE    = 3'd6;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] port;
		logic [31:0] hb;
		logic [31:0] stamp;
	} entry_t;

	// What a cell hands to its lower neighbor.
	typedef struct packed {
		entry_t e;
		logic   valid;
		logic   flag;
	} link_t;

	// Prefix information that runs upward through the row.
	typedef struct packed {
		logic found;
		logic flag;
		logic valid;
	} chain_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now;
		logic [15:0] mid;
		logic [15:0] mport;
		logic [31:0] mhb;
		logic [31:0] own_hb;
		logic [15:0] fail_to;
		logic [15:0] remove_to;
		logic        id_we;
		logic        port_we;
		logic [15:0] cfg_data;
	} cell_ctl_t;

endpackage

[hw/rtl/hmt_in_if.sv]
// Input channel of the membership table: one beat per operation.
interface hmt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] current_time;
	logic [15:0] member_id;
	logic [15:0] member_port;
	logic [31:0] member_heartbeat;

	modport source (output valid, mode, current_time, member_id, member_port,
		member_heartbeat, input ready);
	modport sink (input valid, mode, current_time, member_id, member_port,
		member_heartbeat, output ready);
endinterface

[hw/rtl/hmt_out_if.sv]
// Result channel of the membership table: one beat per result.
interface hmt_out_if;
	logic        valid;
	logic        ready;
	logic        added;
	logic        dropped_full;
	logic [5:0]  removed_count;
	logic [5:0]  entry_count;
	logic [15:0] entry_id;
	logic [15:0] entry_port;
	logic [31:0] entry_heartbeat;
	logic        entry_present;
	logic        last;

	modport source (output valid, added, dropped_full, removed_count, entry_count,
		entry_id, entry_port, entry_heartbeat, entry_present, last, input ready);
	modport sink (input valid, added, dropped_full, removed_count, entry_count,
		entry_id, entry_port, entry_heartbeat, entry_present, last, output ready);
endinterface

[hw/rtl/hmt_cell.sv]
// One slot of the member table, with its flag and its links to both neighbors.
module hmt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head,
	input  hmt_pkg::cell_ctl_t ctl,
	input  logic               hit_any,
	input  hmt_pkg::link_t     nbr,
	input  hmt_pkg::chain_t    chain_lo,
	output hmt_pkg::link_t     link,
	output hmt_pkg::chain_t    chain_hi
);

	hmt_pkg::entry_t e_q;
	logic            valid_q;
	logic            flag_q;
	logic [31:0]     age;
	logic            match;
	logic            win;
	logic            append;

	assign age    = ctl.now - e_q.stamp;
	assign match  = valid_q && (e_q.id == ctl.mid) && (e_q.port == ctl.mport);
	assign win    = match && !chain_lo.found;
	assign append = !valid_q && chain_lo.valid && !hit_any;

	assign link.e     = e_q;
	assign link.valid = valid_q;
	assign link.flag  = flag_q;

	assign chain_hi.found = chain_lo.found | match;
	assign chain_hi.flag  = chain_lo.flag | flag_q;
	assign chain_hi.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q     <= '0;
			valid_q <= head;
			flag_q  <= 1'b0;
		end else begin
			case (ctl.op)
				hmt_pkg::CELL_MERGE: begin
					if (win && (ctl.mhb > e_q.hb)) begin
						e_q.hb    <= ctl.mhb;
						e_q.stamp <= ctl.now;
					end
					if (append) begin
						e_q.id    <= ctl.mid;
						e_q.port  <= ctl.mport;
						e_q.hb    <= ctl.mhb;
						e_q.stamp <= ctl.now;
						valid_q   <= 1'b1;
					end
				end
				hmt_pkg::CELL_HEAD_TICK: begin
					if (head) begin
						e_q.hb    <= ctl.own_hb;
						e_q.stamp <= ctl.now;
					end
				end
				hmt_pkg::CELL_MARK_DEAD: begin
					flag_q <= valid_q && (age > {16'd0, ctl.remove_to});
				end
				hmt_pkg::CELL_MARK_LIVE: begin
					flag_q <= valid_q && (age < {16'd0, ctl.fail_to});
				end
				hmt_pkg::CELL_COMPACT: begin
					// Everything from the lowest deleted slot upward moves down one place.
					if (chain_lo.flag || flag_q) begin
						e_q     <= nbr.e;
						valid_q <= nbr.valid;
						flag_q  <= nbr.flag;
					end
				end
				hmt_pkg::CELL_ROTATE: begin
					e_q     <= nbr.e;
					valid_q <= nbr.valid;
					flag_q  <= nbr.flag;
				end
				default: begin
				end
			endcase
			if (head && ctl.id_we) begin
				e_q.id <= ctl.cfg_data;
			end
			if (head && ctl.port_we) begin
				e_q.port <= ctl.cfg_data;
			end
		end
	end

endmodule

[hw/rtl/heartbeat_membership_table.sv]
// Top level of the heartbeat membership table: cell row, sequencer and register port.
//
//   channel  dir  handshake                 carries
//   req      in   valid/ready               mode, current_time, member fields
//   rsp      out  valid/ready               flags, counts, dumped entry, last
//   apb      in   psel/penable/pwrite/...   own_id, own_port, timeouts
//
// A tick compacts the row one deleted entry at a time; a dump with live entries turns
// the cell row through TABLE_DEPTH rotation steps, one per cycle unless a live head
// entry waits for rsp, and an empty dump gives a single empty result. One operation is
// in flight at a time; req is ready only while the sequencer is idle. Reset leaves only
// the own entry in the table, stamp and heartbeat zero. A stalled rsp holds the rotation
// of a dump at the next live entry and holds the final result of the other modes.
module heartbeat_membership_table (
	input  logic                       clk,
	input  logic                       arst_n,
	hmt_in_if.sink                     req,
	hmt_out_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hmt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MERGE     = 4'd1;
	localparam logic [3:0] ST_TICK_HEAD = 4'd2;
	localparam logic [3:0] ST_TICK_MARK = 4'd3;
	localparam logic [3:0] ST_TICK_PACK = 4'd4;
	localparam logic [3:0] ST_DUMP_MARK = 4'd5;
	localparam logic [3:0] ST_DUMP_ROT  = 4'd6;
	localparam logic [3:0] ST_OTHER     = 4'd7;

	localparam int D = hmt_pkg::TABLE_DEPTH;

	logic [3:0] state_q;

	// Configuration registers and the node's own heartbeat counter.
	logic [15:0] own_id_q;
	logic [15:0] own_port_q;
	logic [15:0] fail_to_q;
	logic [15:0] remove_to_q;
	logic [31:0] own_hb_q;

	// The operation being worked on, captured at accept.
	logic [31:0] now_q;
	logic [15:0] mid_q;
	logic [15:0] mport_q;
	logic [31:0] mhb_q;

	logic [hmt_pkg::CNT_W-1:0] used_q;
	logic [hmt_pkg::CNT_W-1:0] removed_q;
	logic [hmt_pkg::IDX_W-1:0] rot_q;

	// Result register.
	logic        out_valid_q;
	logic        added_q;
	logic        dropped_q;
	logic [5:0]  removed_out_q;
	logic [5:0]  count_out_q;
	logic [15:0] id_out_q;
	logic [15:0] port_out_q;
	logic [31:0] hb_out_q;
	logic        present_q;
	logic        last_q;

	hmt_pkg::cell_ctl_t ctl;
	hmt_pkg::link_t     links [D];
	hmt_pkg::link_t     nbrs [D];
	hmt_pkg::chain_t    chains [D+1];

	logic cfg_we;
	logic in_acc;
	logic out_free;
	logic hit_any;
	logic any_flag;
	logic rest_flag;
	logic full;
	logic rot_step;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite;
	assign in_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;
	assign hit_any  = chains[D].found;
	assign any_flag = chains[D].flag;
	assign full     = (used_q == hmt_pkg::CNT_W'(D));

	// A rotation step waits only when the head entry is live and the result
	// register cannot take it.
	assign rot_step = !links[0].flag || out_free;

	always_comb begin
		rest_flag = 1'b0;
		for (int i = 1; i < D; i++) begin
			rest_flag = rest_flag | links[i].flag;
		end
	end

	always_comb begin
		case (paddr[hmt_pkg::ADDR_W-1:2])
			hmt_pkg::REG_OWN_ID:    prdata = {16'd0, own_id_q};
			hmt_pkg::REG_OWN_PORT:  prdata = {16'd0, own_port_q};
			hmt_pkg::REG_FAIL_TO:   prdata = {16'd0, fail_to_q};
			hmt_pkg::REG_REMOVE_TO: prdata = {16'd0, remove_to_q};
			default:                prdata = 32'd0;
		endcase
	end

	// Command to the cell row.
	always_comb begin
		ctl.op        = hmt_pkg::CELL_HOLD;
		ctl.now       = now_q;
		ctl.mid       = mid_q;
		ctl.mport     = mport_q;
		ctl.mhb       = mhb_q;
		ctl.own_hb    = own_hb_q + 32'd1;
		ctl.fail_to   = fail_to_q;
		ctl.remove_to = remove_to_q;
		ctl.id_we     = cfg_we && (paddr[hmt_pkg::ADDR_W-1:2] == hmt_pkg::REG_OWN_ID);
		ctl.port_we   = cfg_we && (paddr[hmt_pkg::ADDR_W-1:2] == hmt_pkg::REG_OWN_PORT);
		ctl.cfg_data  = pwdata[15:0];
		case (state_q)
			ST_MERGE: begin
				if (out_free) begin
					ctl.op = hmt_pkg::CELL_MERGE;
				end
			end
			ST_TICK_HEAD: ctl.op = hmt_pkg::CELL_HEAD_TICK;
			ST_TICK_MARK: ctl.op = hmt_pkg::CELL_MARK_DEAD;
			ST_TICK_PACK: begin
				if (any_flag) begin
					ctl.op = hmt_pkg::CELL_COMPACT;
				end
			end
			ST_DUMP_MARK: ctl.op = hmt_pkg::CELL_MARK_LIVE;
			ST_DUMP_ROT: begin
				if (!((rot_q == '0) && !any_flag) && rot_step) begin
					ctl.op = hmt_pkg::CELL_ROTATE;
				end
			end
			default: ctl.op = hmt_pkg::CELL_HOLD;
		endcase
	end

	// The row: cell i takes from cell i+1; the top cell takes the head entry
	// during a rotation and an empty slot otherwise.
	assign chains[0].found = 1'b0;
	assign chains[0].flag  = 1'b0;
	assign chains[0].valid = 1'b1;

	for (genvar i = 0; i < D; i++) begin : g_cell
		if (i == D - 1) begin : g_top
			assign nbrs[i].e     = links[0].e;
			assign nbrs[i].valid = (ctl.op == hmt_pkg::CELL_ROTATE) && links[0].valid;
			assign nbrs[i].flag  = 1'b0;
		end else begin : g_mid
			assign nbrs[i] = links[i+1];
		end
		hmt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.head     ((i == 0) ? 1'b1 : 1'b0),
			.ctl      (ctl),
			.hit_any  (hit_any),
			.nbr      (nbrs[i]),
			.chain_lo (chains[i]),
			.link     (links[i]),
			.chain_hi (chains[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= 16'd0;
			own_port_q  <= 16'd0;
			fail_to_q   <= 16'd5;
			remove_to_q <= 16'd20;
		end else if (cfg_we) begin
			case (paddr[hmt_pkg::ADDR_W-1:2])
				hmt_pkg::REG_OWN_ID:    own_id_q    <= pwdata[15:0];
				hmt_pkg::REG_OWN_PORT:  own_port_q  <= pwdata[15:0];
				hmt_pkg::REG_FAIL_TO:   fail_to_q   <= pwdata[15:0];
				hmt_pkg::REG_REMOVE_TO: remove_to_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q   <= req.current_time;
			mid_q   <= req.member_id;
			mport_q <= req.member_port;
			mhb_q   <= req.member_heartbeat;
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= hmt_pkg::CNT_W'(1);
			removed_q     <= '0;
			rot_q         <= '0;
			own_hb_q      <= 32'd0;
			out_valid_q   <= 1'b0;
			added_q       <= 1'b0;
			dropped_q     <= 1'b0;
			removed_out_q <= 6'd0;
			count_out_q   <= 6'd0;
			id_out_q      <= 16'd0;
			port_out_q    <= 16'd0;
			hb_out_q      <= 32'd0;
			present_q     <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req.mode)
							hmt_pkg::MODE_MERGE: state_q <= ST_MERGE;
							hmt_pkg::MODE_TICK:  state_q <= ST_TICK_HEAD;
							hmt_pkg::MODE_DUMP:  state_q <= ST_DUMP_MARK;
							default:             state_q <= ST_OTHER;
						endcase
					end
				end
				ST_MERGE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						added_q       <= !hit_any && !full;
						dropped_q     <= !hit_any && full;
						removed_out_q <= 6'd0;
						count_out_q   <= 6'(used_q + ((!hit_any && !full) ?
							hmt_pkg::CNT_W'(1) : hmt_pkg::CNT_W'(0)));
						id_out_q      <= 16'd0;
						port_out_q    <= 16'd0;
						hb_out_q      <= 32'd0;
						present_q     <= 1'b0;
						last_q        <= 1'b1;
						if (!hit_any && !full) begin
							used_q <= used_q + hmt_pkg::CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TICK_HEAD: begin
					own_hb_q  <= own_hb_q + 32'd1;
					removed_q <= '0;
					state_q   <= ST_TICK_MARK;
				end
				ST_TICK_MARK: begin
					state_q <= ST_TICK_PACK;
				end
				ST_TICK_PACK: begin
					// One deleted entry leaves the row per cycle.
					if (any_flag) begin
						used_q    <= used_q - hmt_pkg::CNT_W'(1);
						removed_q <= removed_q + hmt_pkg::CNT_W'(1);
					end else if (out_free) begin
						out_valid_q   <= 1'b1;
						added_q       <= 1'b0;
						dropped_q     <= 1'b0;
						removed_out_q <= 6'(removed_q);
						count_out_q   <= 6'(used_q);
						id_out_q      <= 16'd0;
						port_out_q    <= 16'd0;
						hb_out_q      <= 32'd0;
						present_q     <= 1'b0;
						last_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_DUMP_MARK: begin
					rot_q   <= '0;
					state_q <= ST_DUMP_ROT;
				end
				ST_DUMP_ROT: begin
					if ((rot_q == '0) && !any_flag) begin
						// No live entry: a single empty result, table untouched.
						if (out_free) begin
							out_valid_q   <= 1'b1;
							added_q       <= 1'b0;
							dropped_q     <= 1'b0;
							removed_out_q <= 6'd0;
							count_out_q   <= 6'(used_q);
							id_out_q      <= 16'd0;
							port_out_q    <= 16'd0;
							hb_out_q      <= 32'd0;
							present_q     <= 1'b0;
							last_q        <= 1'b1;
							state_q       <= ST_IDLE;
						end
					end else if (rot_step) begin
						// The whole row turns once; live entries go out from the head.
						if (links[0].flag) begin
							out_valid_q   <= 1'b1;
							added_q       <= 1'b0;
							dropped_q     <= 1'b0;
							removed_out_q <= 6'd0;
							count_out_q   <= 6'(used_q);
							id_out_q      <= links[0].e.id;
							port_out_q    <= links[0].e.port;
							hb_out_q      <= links[0].e.hb;
							present_q     <= 1'b1;
							last_q        <= !rest_flag;
						end
						rot_q <= rot_q + hmt_pkg::IDX_W'(1);
						if (rot_q == hmt_pkg::IDX_W'(D - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OTHER: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						added_q       <= 1'b0;
						dropped_q     <= 1'b0;
						removed_out_q <= 6'd0;
						count_out_q   <= 6'(used_q);
						id_out_q      <= 16'd0;
						port_out_q    <= 16'd0;
						hb_out_q      <= 32'd0;
						present_q     <= 1'b0;
						last_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.added           = added_q;
	assign rsp.dropped_full    = dropped_q;
	assign rsp.removed_count   = removed_out_q;
	assign rsp.entry_count     = count_out_q;
	assign rsp.entry_id        = id_out_q;
	assign rsp.entry_port      = port_out_q;
	assign rsp.entry_heartbeat = hb_out_q;
	assign rsp.entry_present   = present_q;
	assign rsp.last            = last_q;

endmodule
